// ===== hw/rtl/usrp_pkg.sv =====
// Shared types and constants for the URL scheme and route parser.
// Used by the step logic, the output buffer, the top level and the checker.
package usrp_pkg;

  localparam int unsigned MAX_ROUTE_LEN_DEF = 1024;

  localparam int unsigned PhaseW = 3;
  localparam logic [PhaseW-1:0] PH_SCHEME = 3'd0;
  localparam logic [PhaseW-1:0] PH_SLASH1 = 3'd1;
  localparam logic [PhaseW-1:0] PH_SLASH2 = 3'd2;
  localparam logic [PhaseW-1:0] PH_AUTH   = 3'd3;
  localparam logic [PhaseW-1:0] PH_ROUTE  = 3'd4;
  localparam logic [PhaseW-1:0] PH_DRAIN  = 3'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_CHAR = 3'd1;
  localparam logic [2:0] ST_NO_COLON = 3'd2;
  localparam logic [2:0] ST_NO_SLASH = 3'd3;
  localparam logic [2:0] ST_TOO_LONG = 3'd4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_QUEST = 8'h3f;
  localparam logic [7:0] CH_HASH  = 8'h23;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       part;
    logic       done_res;
    logic [2:0] status;
  } usrp_res_t;

  function automatic logic is_scheme_char(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a) ||
           c == CH_DASH || c == CH_PLUS || c == CH_DOT;
  endfunction

endpackage

// ===== hw/rtl/url_scheme_route_parser_top.sv =====
// A result is registered in the output register, or in the skid stage on a stall.
// Throughput: one byte per cycle; in_ready_o drops only while the skid stage
// holds a request that the consumer has not yet taken.
// Reset (rst_ni low, asynchronous): scheme phase, route count zero, output empty.
// Depends on usrp_pkg, usrp_step and usrp_outbuf.
module url_scheme_route_parser_top #(
  parameter int unsigned MAX_ROUTE_LEN = usrp_pkg::MAX_ROUTE_LEN_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] url_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       has_byte_o,
  output logic       part_o,
  output logic       done_res_o,
  output logic [2:0] status_o
);
  import usrp_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_ROUTE_LEN);

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              res_valid;
  usrp_res_t         res;
  usrp_res_t         out_res;
  logic              accept;

  assign accept = in_valid_i && in_ready_o;

  usrp_step #(
    .MAX_ROUTE_LEN(MAX_ROUTE_LEN)
  ) u_step (
    .phase_i    (phase_q),
    .count_i    (count_q),
    .url_byte_i (url_byte_i),
    .phase_o    (phase_d),
    .count_o    (count_d),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SCHEME;
      count_q <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

  usrp_outbuf u_outbuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept && res_valid),
    .data_i (res),
    .ready_o(in_ready_o),
    .valid_o(out_valid_o),
    .ready_i(out_ready_i),
    .data_o (out_res)
  );

  assign out_byte_o = out_res.out_byte;
  assign has_byte_o = out_res.has_byte;
  assign part_o     = out_res.part;
  assign done_res_o = out_res.done_res;
  assign status_o   = out_res.status;

endmodule

// ===== hw/rtl/usrp_step.sv =====
// Next-phase, route count and result logic for one URL byte.
// Purely combinational; depends on usrp_pkg.
module usrp_step #(
  parameter int unsigned MAX_ROUTE_LEN = usrp_pkg::MAX_ROUTE_LEN_DEF,
  localparam int unsigned CntW = $clog2(MAX_ROUTE_LEN)
) (
  input  logic [usrp_pkg::PhaseW-1:0] phase_i,
  input  logic [CntW-1:0]             count_i,
  input  logic [7:0]                  url_byte_i,
  output logic [usrp_pkg::PhaseW-1:0] phase_o,
  output logic [CntW-1:0]             count_o,
  output logic                        res_valid_o,
  output usrp_pkg::usrp_res_t         res_o
);
  import usrp_pkg::*;

  localparam logic [CntW-1:0] CntLast = CntW'(MAX_ROUTE_LEN - 1);

  logic is_nul;
  logic is_stop;
  logic [PhaseW-1:0] end_phase;

  assign is_nul    = (url_byte_i == CH_NUL);
  assign is_stop   = is_nul || url_byte_i == CH_QUEST || url_byte_i == CH_HASH;
  // a done result before the zero byte leaves the rest of the URL to drain
  assign end_phase = is_nul ? PH_SCHEME : PH_DRAIN;

  always_comb begin
    phase_o     = phase_i;
    count_o     = count_i;
    res_valid_o = 1'b0;
    res_o       = '0;
    case (phase_i)
      PH_SCHEME: begin
        if (is_nul) begin
          phase_o = end_phase; count_o = '0; res_valid_o = 1'b1;
          res_o.done_res = 1'b1; res_o.status = ST_NO_COLON;
        end else if (url_byte_i == CH_COLON) begin
          phase_o = PH_SLASH1;
        end else if (is_scheme_char(url_byte_i)) begin
          res_valid_o = 1'b1;
          res_o.out_byte = url_byte_i; res_o.has_byte = 1'b1;
        end else begin
          phase_o = end_phase; count_o = '0; res_valid_o = 1'b1;
          res_o.done_res = 1'b1; res_o.status = ST_BAD_CHAR;
        end
      end
      PH_SLASH1, PH_SLASH2: begin
        if (url_byte_i != CH_SLASH) begin
          phase_o = end_phase; count_o = '0; res_valid_o = 1'b1;
          res_o.done_res = 1'b1; res_o.status = ST_NO_SLASH;
        end else begin
          phase_o = (phase_i == PH_SLASH1) ? PH_SLASH2 : PH_AUTH;
        end
      end
      PH_AUTH: begin
        if (is_stop) begin
          // empty route: emit the default slash with the done result
          phase_o = end_phase; count_o = '0; res_valid_o = 1'b1;
          res_o.out_byte = CH_SLASH; res_o.has_byte = 1'b1; res_o.part = 1'b1;
          res_o.done_res = 1'b1; res_o.status = ST_OK;
        end else if (url_byte_i == CH_SLASH) begin
          phase_o = PH_ROUTE; count_o = CntW'(1); res_valid_o = 1'b1;
          res_o.out_byte = url_byte_i; res_o.has_byte = 1'b1; res_o.part = 1'b1;
        end
      end
      PH_ROUTE: begin
        if (is_stop) begin
          phase_o = end_phase; count_o = '0; res_valid_o = 1'b1;
          res_o.done_res = 1'b1; res_o.status = ST_OK;
        end else if (count_i >= CntLast) begin
          phase_o = end_phase; count_o = '0; res_valid_o = 1'b1;
          res_o.done_res = 1'b1; res_o.status = ST_TOO_LONG;
        end else begin
          count_o = count_i + CntW'(1); res_valid_o = 1'b1;
          res_o.out_byte = url_byte_i; res_o.has_byte = 1'b1; res_o.part = 1'b1;
        end
      end
      default: begin
        if (is_nul) begin
          phase_o = PH_SCHEME; count_o = '0;
        end
      end
    endcase
  end

endmodule

// ===== hw/rtl/usrp_outbuf.sv =====
// Result register with a skid stage behind it.
// Depends on usrp_pkg for the result struct.
module usrp_outbuf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  usrp_pkg::usrp_res_t data_i,
  output logic                ready_o,
  output logic                valid_o,
  input  logic                ready_i,
  output usrp_pkg::usrp_res_t data_o
);
  import usrp_pkg::*;

  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;
  usrp_res_t out_q, out_d;
  usrp_res_t skid_q, skid_d;
  logic      pop;

  assign pop     = out_valid_q && ready_i;
  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q && pop) begin
      // advance the parked request; no push can arrive while skid is full
      out_d        = skid_q;
      skid_valid_d = 1'b0;
    end else if (pop || !out_valid_q) begin
      out_d       = data_i;
      out_valid_d = push_i;
    end else if (push_i) begin
      skid_d       = data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

// ===== hw/rtl/usrp_checker.sv =====
// Port-level checks on the parser's result channel, bound to the top level.
// Depends on usrp_pkg for status codes.
module usrp_port_props (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       has_byte_o,
  input logic       part_o,
  input logic       done_res_o,
  input logic [2:0] status_o
);
  import usrp_pkg::*;

  // hold a stalled request
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o) &&
    $stable(done_res_o) && $stable(status_o))
    else $error("stalled result changed");

  a_empty_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_byte_o |-> out_byte_o == 8'h00 && part_o == 1'b0)
    else $error("byte fields set without a byte");

  a_status_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !done_res_o |-> status_o == ST_OK)
    else $error("status set on a non-final result");

  a_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> has_byte_o || done_res_o)
    else $error("result carries neither byte nor done");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> status_o <= ST_TOO_LONG)
    else $error("undefined status code");

endmodule

bind url_scheme_route_parser_top usrp_port_props u_usrp_checker (.*);

// ===== tb/usrp_checker.sv =====
// Checker for the URL scheme and route parser: watches both channels, predicts each
// result from the accepted bytes and compares the results field by field.
// Depends on usrp_pkg for the phase, status and character codes and the result type.
module usrp_checker #(
  parameter int unsigned MAX_ROUTE_LEN = usrp_pkg::MAX_ROUTE_LEN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  url_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  out_byte_i,
  input  logic        has_byte_i,
  input  logic        part_i,
  input  logic        done_res_i,
  input  logic [2:0]  status_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned parsed_pending_o
);
  import usrp_pkg::*;

  logic [PhaseW-1:0] url_phase;
  int unsigned       route_len;
  int unsigned       res_idx;
  usrp_res_t         parsed_q[$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] result %0d: %s", $time, res_idx, msg);
    mismatch_cnt_o++;
  endtask

  function automatic bit scheme_byte(input logic [7:0] c);
    logic [7:0] lc;
    lc = c | 8'h20;
    return (c[7:5] inside {3'b010, 3'b011} && lc >= 8'h61 && lc <= 8'h7a) ||
           c == CH_DASH || c == CH_PLUS || c == CH_DOT;
  endfunction

  // Advance the parse by one byte and queue the result it causes, if any.
  task automatic parse_byte(input logic [7:0] c);
    usrp_res_t r;
    bit        emit;
    r    = '0;
    emit = 1'b0;
    case (url_phase)
      PH_SCHEME: begin
        emit = 1'b1;
        if (c == CH_NUL) begin
          r.done_res = 1'b1;
          r.status   = ST_NO_COLON;
        end else if (c == CH_COLON) begin
          emit      = 1'b0;
          url_phase = PH_SLASH1;
        end else if (scheme_byte(c)) begin
          r.out_byte = c;
          r.has_byte = 1'b1;
        end else begin
          r.done_res = 1'b1;
          r.status   = ST_BAD_CHAR;
        end
      end
      PH_SLASH1, PH_SLASH2: begin
        if (c != CH_SLASH) begin
          emit       = 1'b1;
          r.done_res = 1'b1;
          r.status   = ST_NO_SLASH;
        end else begin
          url_phase = (url_phase == PH_SLASH1) ? PH_SLASH2 : PH_AUTH;
        end
      end
      PH_AUTH: begin
        if (c == CH_NUL || c == CH_QUEST || c == CH_HASH) begin
          // empty route: stand in a single slash
          emit       = 1'b1;
          r.out_byte = CH_SLASH;
          r.has_byte = 1'b1;
          r.part     = 1'b1;
          r.done_res = 1'b1;
          r.status   = ST_OK;
        end else if (c == CH_SLASH) begin
          emit       = 1'b1;
          url_phase  = PH_ROUTE;
          route_len  = 1;
          r.out_byte = c;
          r.has_byte = 1'b1;
          r.part     = 1'b1;
        end
      end
      PH_ROUTE: begin
        emit = 1'b1;
        if (c == CH_NUL || c == CH_QUEST || c == CH_HASH) begin
          r.done_res = 1'b1;
          r.status   = ST_OK;
        end else if (route_len + 1 >= MAX_ROUTE_LEN) begin
          r.done_res = 1'b1;
          r.status   = ST_TOO_LONG;
        end else begin
          route_len++;
          r.out_byte = c;
          r.has_byte = 1'b1;
          r.part     = 1'b1;
        end
      end
      default: begin
        // drop everything up to the terminating zero
        if (c == CH_NUL) begin
          url_phase = PH_SCHEME;
          route_len = 0;
        end
      end
    endcase
    if (r.done_res) begin
      url_phase = (c == CH_NUL) ? PH_SCHEME : PH_DRAIN;
      route_len = 0;
    end
    if (emit) begin
      parsed_q.push_back(r);
    end
  endtask

  always @(posedge clk_i) begin
    usrp_res_t want;
    if (!rst_ni) begin
      url_phase        = PH_SCHEME;
      route_len        = 0;
      res_idx          = 0;
      mismatch_cnt_o   = 0;
      parsed_pending_o = 0;
      parsed_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        parse_byte(url_byte_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (parsed_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result: byte %02h has %0b part %0b",
                                    out_byte_i, has_byte_i, part_i) &&
                          0 ? "" :
                          $sformatf("unexpected result: byte %02h has %0b part %0b done %0b st %0d",
                                    out_byte_i, has_byte_i, part_i, done_res_i, status_i));
        end else begin
          want = parsed_q.pop_front();
          if (out_byte_i !== want.out_byte) begin
            report_mismatch($sformatf("out_byte got %02h want %02h", out_byte_i, want.out_byte));
          end
          if (has_byte_i !== want.has_byte) begin
            report_mismatch($sformatf("has_byte got %0b want %0b", has_byte_i, want.has_byte));
          end
          if (part_i !== want.part) begin
            report_mismatch($sformatf("part got %0b want %0b", part_i, want.part));
          end
          if (done_res_i !== want.done_res) begin
            report_mismatch($sformatf("done_res got %0b want %0b", done_res_i, want.done_res));
          end
          if (status_i !== want.status) begin
            report_mismatch($sformatf("status got %0d want %0d", status_i, want.status));
          end
        end
        res_idx++;
      end
      parsed_pending_o = parsed_q.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the URL scheme and route parser testbench: clock, reset, URL stimulus,
// receiver stalls, stall watchdog and the verdict.
// Depends on usrp_pkg, url_scheme_route_parser_top and usrp_checker.
module tb_top;
  import usrp_pkg::*;

  localparam int unsigned RouteMax    = MAX_ROUTE_LEN_DEF;
  localparam int unsigned RandomBytes = 800;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned StallLimit  = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  url_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        has_byte;
  logic        part;
  logic        done_res;
  logic [2:0]  status;
  int unsigned mismatch_cnt;
  int unsigned parsed_pending;

  int unsigned src_idle_pct = 17;
  int unsigned sink_idle_pct = 75;
  bit          hold_req = 1'b0;
  int unsigned quiet_cycles = 0;
  logic [7:0]  url_bytes[$];

  always #5 clk = ~clk;

  url_scheme_route_parser_top #(
    .MAX_ROUTE_LEN(RouteMax)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .url_byte_i (url_byte),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_byte_o (out_byte),
    .has_byte_o (has_byte),
    .part_o     (part),
    .done_res_o (done_res),
    .status_o   (status)
  );

  usrp_checker #(
    .MAX_ROUTE_LEN(RouteMax)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .url_byte_i      (url_byte),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .out_byte_i      (out_byte),
    .has_byte_i      (has_byte),
    .part_i          (part),
    .done_res_i      (done_res),
    .status_i        (status),
    .mismatch_cnt_o  (mismatch_cnt),
    .parsed_pending_o(parsed_pending)
  );

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] pick_byte(input bit slash_ok);
    logic [7:0] b;
    do begin
      b = $urandom_range(1) ? 8'($urandom_range(8'h7e, 8'h21)) : 8'($urandom_range(255, 1));
    end while (b == CH_QUEST || b == CH_HASH || (!slash_ok && b == CH_SLASH));
    return b;
  endfunction

  function automatic logic [7:0] pick_scheme_byte();
    case ($urandom_range(4))
      0:       return CH_DASH;
      1:       return CH_PLUS;
      2:       return CH_DOT;
      3:       return 8'($urandom_range(8'h5a, 8'h41));
      default: return 8'($urandom_range(8'h7a, 8'h61));
    endcase
  endfunction

  function automatic void push_str(input string s);
    for (int i = 0; i < s.len(); i++) begin
      url_bytes.push_back(s[i]);
    end
  endfunction

  // Mostly well-formed URLs with random content; the rest corrupted or plain noise.
  function automatic void build_url();
    int unsigned kind;
    kind = $urandom_range(99);
    url_bytes.delete();
    repeat ($urandom_range(6)) url_bytes.push_back(pick_scheme_byte());
    push_str("://");
    repeat ($urandom_range(5)) url_bytes.push_back(pick_byte(1'b0));
    if ($urandom_range(3) != 0) begin
      url_bytes.push_back(CH_SLASH);
      repeat ($urandom_range(12)) url_bytes.push_back(pick_byte(1'b1));
    end
    case ($urandom_range(2))
      0:       ;
      1:       url_bytes.push_back(CH_QUEST);
      default: url_bytes.push_back(CH_HASH);
    endcase
    repeat ($urandom_range(2)) url_bytes.push_back(8'($urandom_range(255, 1)));
    url_bytes.push_back(CH_NUL);
    if (kind >= 70 && kind < 88) begin
      url_bytes[$urandom_range(url_bytes.size() - 1)] = 8'($urandom_range(255));
    end else if (kind >= 88) begin
      url_bytes.delete();
      repeat ($urandom_range(10, 1)) url_bytes.push_back(8'($urandom_range(255, 1)));
      url_bytes.push_back(CH_NUL);
    end
  endfunction

  // Present one request and hold it until taken.
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid <= 1'b1;
    url_byte <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_url();
    foreach (url_bytes[i]) begin
      send_byte(url_bytes[i]);
    end
  endtask

  // Lead with a zero byte so the route starts from the scheme phase whatever came before.
  task automatic send_long_route(input int unsigned extra);
    url_bytes.delete();
    url_bytes.push_back(CH_NUL);
    push_str(":///");
    repeat (extra) url_bytes.push_back(pick_byte(1'b1));
    url_bytes.push_back(CH_NUL);
    send_url();
  endtask

  initial begin : stimulus
    int unsigned sent;
    sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extreme bytes, empty scheme, bad scheme byte, no colon,
    // missing slashes, empty route at '?' and at the end, route end at '#'.
    url_bytes.delete();
    push_str("z:///");
    url_bytes.push_back(8'hff);
    push_str("#");
    url_bytes.push_back(CH_NUL);
    push_str(":/");
    url_bytes.push_back(CH_NUL);
    push_str("A");
    url_bytes.push_back(8'h80);
    push_str("q");
    url_bytes.push_back(CH_NUL);
    url_bytes.push_back(CH_NUL);
    push_str("+-.://h?");
    url_bytes.push_back(CH_NUL);
    push_str("://");
    url_bytes.push_back(CH_NUL);
    send_url();

    for (int m = 0; m < 3; m++) begin
      src_idle_pct  = (m == 0) ? 17 : (m == 1) ? 75 : 0;
      sink_idle_pct = (m == 0) ? 75 : (m == 1) ? 17 : 0;
      if (m == 2) begin
        hold_req = 1'b1;
      end
      while (sent < (m + 1) * RandomBytes / 3) begin
        build_url();
        sent += url_bytes.size();
        send_url();
      end
      if (m == 2) begin
        // longest route that passes, then one byte more
        send_long_route(RouteMax - 2);
        send_long_route(RouteMax - 1);
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    wait (parsed_pending == 0);
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/usrp_pkg.sv
hw/rtl/usrp_step.sv
hw/rtl/usrp_outbuf.sv
hw/rtl/url_scheme_route_parser_top.sv
hw/rtl/usrp_checker.sv
tb/usrp_checker.sv
tb/tb_top.sv
